FILE: rtl/swtsp_pkg.sv
// ----------------------------------------------------------------------------
// swtsp_pkg
// Shared constants and helpers for the segwit transaction stream parser:
// parse phase codes, field kind codes, error codes and varint prefixes.
// ----------------------------------------------------------------------------
package swtsp_pkg;

  localparam int unsigned LENGTH_BITS = 32;

  localparam int unsigned PHASE_W = 5;
  localparam int unsigned KIND_W  = 5;
  localparam int unsigned ERR_W   = 2;

  localparam logic [PHASE_W-1:0] P_IDLE      = 5'd0;
  localparam logic [PHASE_W-1:0] P_VERSION   = 5'd1;
  localparam logic [PHASE_W-1:0] P_INCOUNT   = 5'd2;
  localparam logic [PHASE_W-1:0] P_FLAG      = 5'd3;
  localparam logic [PHASE_W-1:0] P_INCOUNT2  = 5'd4;
  localparam logic [PHASE_W-1:0] P_PREVHASH  = 5'd5;
  localparam logic [PHASE_W-1:0] P_PREVIDX   = 5'd6;
  localparam logic [PHASE_W-1:0] P_INSLEN    = 5'd7;
  localparam logic [PHASE_W-1:0] P_INSCRIPT  = 5'd8;
  localparam logic [PHASE_W-1:0] P_SEQ       = 5'd9;
  localparam logic [PHASE_W-1:0] P_OUTCOUNT  = 5'd10;
  localparam logic [PHASE_W-1:0] P_AMOUNT    = 5'd11;
  localparam logic [PHASE_W-1:0] P_OUTSLEN   = 5'd12;
  localparam logic [PHASE_W-1:0] P_OUTSCRIPT = 5'd13;
  localparam logic [PHASE_W-1:0] P_WITCOUNT  = 5'd14;
  localparam logic [PHASE_W-1:0] P_WITLEN    = 5'd15;
  localparam logic [PHASE_W-1:0] P_WITBYTE   = 5'd16;
  localparam logic [PHASE_W-1:0] P_LOCK      = 5'd17;
  localparam logic [PHASE_W-1:0] P_SKIP      = 5'd18;

  localparam logic [KIND_W-1:0] K_VERSION      = 5'd0;
  localparam logic [KIND_W-1:0] K_MARKER       = 5'd1;
  localparam logic [KIND_W-1:0] K_FLAG         = 5'd2;
  localparam logic [KIND_W-1:0] K_INCOUNT      = 5'd3;
  localparam logic [KIND_W-1:0] K_PREVHASH     = 5'd4;
  localparam logic [KIND_W-1:0] K_PREVIDX      = 5'd5;
  localparam logic [KIND_W-1:0] K_INSCRIPTLEN  = 5'd6;
  localparam logic [KIND_W-1:0] K_INSCRIPT     = 5'd7;
  localparam logic [KIND_W-1:0] K_SEQ          = 5'd8;
  localparam logic [KIND_W-1:0] K_OUTCOUNT     = 5'd9;
  localparam logic [KIND_W-1:0] K_AMOUNT       = 5'd10;
  localparam logic [KIND_W-1:0] K_OUTSCRIPTLEN = 5'd11;
  localparam logic [KIND_W-1:0] K_OUTSCRIPT    = 5'd12;
  localparam logic [KIND_W-1:0] K_WITCOUNT     = 5'd13;
  localparam logic [KIND_W-1:0] K_WITLEN       = 5'd14;
  localparam logic [KIND_W-1:0] K_WITBYTE      = 5'd15;
  localparam logic [KIND_W-1:0] K_LOCKTIME     = 5'd16;
  localparam logic [KIND_W-1:0] K_SKIPPED      = 5'd17;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_FLAG = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_BIG  = 2'd2;

  localparam logic [7:0] VARINT_PREFIX16 = 8'hfd;
  localparam logic [7:0] VARINT_PREFIX32 = 8'hfe;
  localparam logic [7:0] SEGWIT_FLAG     = 8'h01;

  localparam logic [3:0] VARINT_BYTES16 = 4'd2;
  localparam logic [3:0] VARINT_BYTES32 = 4'd4;
  localparam logic [3:0] VARINT_BYTES64 = 4'd8;
  localparam logic [3:0] FIXED_BYTES32  = 4'd4;
  localparam logic [3:0] FIXED_BYTES64  = 4'd8;

  localparam int unsigned PREVHASH_BYTES = 32;

  function automatic logic [KIND_W-1:0] kind_of(logic [PHASE_W-1:0] ph);
    logic [KIND_W-1:0] k;
    case (ph)
      P_VERSION:   k = K_VERSION;
      P_INCOUNT:   k = K_INCOUNT;
      P_FLAG:      k = K_FLAG;
      P_INCOUNT2:  k = K_INCOUNT;
      P_PREVHASH:  k = K_PREVHASH;
      P_PREVIDX:   k = K_PREVIDX;
      P_INSLEN:    k = K_INSCRIPTLEN;
      P_INSCRIPT:  k = K_INSCRIPT;
      P_SEQ:       k = K_SEQ;
      P_OUTCOUNT:  k = K_OUTCOUNT;
      P_AMOUNT:    k = K_AMOUNT;
      P_OUTSLEN:   k = K_OUTSCRIPTLEN;
      P_OUTSCRIPT: k = K_OUTSCRIPT;
      P_WITCOUNT:  k = K_WITCOUNT;
      P_WITLEN:    k = K_WITLEN;
      P_WITBYTE:   k = K_WITBYTE;
      P_LOCK:      k = K_LOCKTIME;
      default:     k = K_SKIPPED;
    endcase
    return k;
  endfunction

  function automatic logic too_big(logic [63:0] v);
    logic [63:0] hi;
    hi = (LENGTH_BITS >= 64) ? 64'd0 : (v >> LENGTH_BITS);
    return hi != 64'd0;
  endfunction

endpackage

FILE: rtl/segwit_transaction_stream_parser.sv
// ----------------------------------------------------------------------------
// segwit_transaction_stream_parser
// Byte-serial parser for serialized transactions with optional witness data.
// An accepted byte's result is registered and shows on the output port in the next cycle.
// Throughput: one byte per cycle while the output is not stalled; the parse state updates in a single pass.
// A stalled result holds off the input; a new byte enters as the result leaves.
// Reset clears the parse state to waiting for a start byte, with no result.
// ----------------------------------------------------------------------------
module segwit_transaction_stream_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             start_of_tx_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [swtsp_pkg::KIND_W-1:0]     field_kind_o,
  output logic [7:0]                       data_out_o,
  output logic                             in_txid_o,
  output logic                             value_valid_o,
  output logic [63:0]                      field_value_o,
  output logic [31:0]                      item_index_o,
  output logic                             tx_done_o,
  output logic [31:0]                      total_length_o,
  output logic [31:0]                      stripped_length_o,
  output logic                             is_segwit_o,
  output logic [swtsp_pkg::ERR_W-1:0]      error_code_o
);
  import swtsp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] PREVHASH_LEN = LENGTH_BITS'(PREVHASH_BYTES);
  localparam logic [LENGTH_BITS-1:0] LEN_ONE      = LENGTH_BITS'(1);

  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [3:0]             bif_q, bif_d;
  logic [3:0]             vleft_q, vleft_d;
  logic [63:0]            accum_q, accum_d;
  logic                   segwit_q, segwit_d;
  logic [LENGTH_BITS-1:0] input_total_q, input_total_d;
  logic [LENGTH_BITS-1:0] list_left_q, list_left_d;
  logic [LENGTH_BITS-1:0] wit_left_q, wit_left_d;
  logic [LENGTH_BITS-1:0] pay_left_q, pay_left_d;
  logic [31:0]            item_cnt_q, item_cnt_d;
  logic [31:0]            total_cnt_q, total_cnt_d;
  logic [31:0]            strip_cnt_q, strip_cnt_d;

  logic                   out_valid_q, out_valid_d;
  logic [KIND_W-1:0]      kind_q, kind_d;
  logic [7:0]             data_q;
  logic                   txid_q, txid_d;
  logic                   vvalid_q, vvalid_d;
  logic [63:0]            value_q, value_d;
  logic [31:0]            index_q, index_d;
  logic                   done_q, done_d;
  logic [31:0]            total_len_q, total_len_d;
  logic [31:0]            strip_len_q, strip_len_d;
  logic                   is_segwit_q;
  logic [ERR_W-1:0]       err_q, err_d;

  logic                   accept;
  logic [3:0]             cur_bif, cur_vleft;
  logic [63:0]            cur_accum;
  logic [63:0]            lane;
  logic [3:0]             fix_n;
  logic [3:0]             f_bif;
  logic [63:0]            f_acc;
  logic                   f_done;
  logic [3:0]             v_bif, v_vleft;
  logic [63:0]            v_acc, v_val;
  logic                   v_done;
  logic [PHASE_W-1:0]     ph;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign cur_bif   = start_of_tx_i ? 4'd0 : bif_q;
  assign cur_vleft = start_of_tx_i ? 4'd0 : vleft_q;
  assign cur_accum = start_of_tx_i ? 64'd0 : accum_q;
  assign lane      = {56'd0, data_byte_i} << {cur_bif[2:0], 3'b000};

  always_comb begin
    fix_n  = (phase_q == P_AMOUNT && !start_of_tx_i) ? FIXED_BYTES64 : FIXED_BYTES32;
    f_acc  = cur_accum | lane;
    f_bif  = cur_bif + 4'd1;
    f_done = (f_bif >= fix_n);
    if (f_done) begin
      f_acc = 64'd0;
      f_bif = 4'd0;
    end
  end

  always_comb begin
    v_bif   = cur_bif;
    v_vleft = cur_vleft;
    v_acc   = cur_accum;
    v_val   = 64'd0;
    v_done  = 1'b0;
    if (cur_vleft == 4'd0) begin
      if (data_byte_i < VARINT_PREFIX16) begin
        v_val  = {56'd0, data_byte_i};
        v_done = 1'b1;
      end else begin
        v_vleft = (data_byte_i == VARINT_PREFIX16) ? VARINT_BYTES16 :
                  (data_byte_i == VARINT_PREFIX32) ? VARINT_BYTES32 : VARINT_BYTES64;
        v_acc   = 64'd0;
        v_bif   = 4'd0;
      end
    end else begin
      v_acc   = cur_accum | lane;
      v_bif   = cur_bif + 4'd1;
      v_vleft = cur_vleft - 4'd1;
      if (v_vleft == 4'd0) begin
        v_val  = v_acc;
        v_done = 1'b1;
        v_acc  = 64'd0;
        v_bif  = 4'd0;
      end
    end
  end

  always_comb begin
    phase_d       = phase_q;
    bif_d         = bif_q;
    vleft_d       = vleft_q;
    accum_d       = accum_q;
    segwit_d      = segwit_q;
    input_total_d = input_total_q;
    list_left_d   = list_left_q;
    wit_left_d    = wit_left_q;
    pay_left_d    = pay_left_q;
    item_cnt_d    = item_cnt_q;
    total_cnt_d   = total_cnt_q;
    strip_cnt_d   = strip_cnt_q;
    txid_d        = 1'b1;
    vvalid_d      = 1'b0;
    value_d       = 64'd0;
    index_d       = 32'd0;
    done_d        = 1'b0;
    err_d         = ERR_NONE;

    if (start_of_tx_i) begin
      bif_d         = 4'd0;
      vleft_d       = 4'd0;
      accum_d       = 64'd0;
      segwit_d      = 1'b0;
      input_total_d = '0;
      list_left_d   = '0;
      wit_left_d    = '0;
      pay_left_d    = '0;
      item_cnt_d    = 32'd0;
      total_cnt_d   = 32'd0;
      strip_cnt_d   = 32'd0;
      phase_d       = P_VERSION;
    end

    ph     = (phase_d > P_SKIP) ? P_SKIP : phase_d;
    kind_d = kind_of(ph);

    if (ph == P_IDLE || ph == P_SKIP) begin
      txid_d = 1'b0;
    end else begin
      total_cnt_d = total_cnt_d + 32'd1;
      if (ph inside {[P_PREVHASH:P_SEQ], [P_AMOUNT:P_WITBYTE]}) begin
        index_d = item_cnt_d;
      end

      case (ph)
        P_VERSION, P_PREVIDX, P_SEQ, P_AMOUNT: begin
          bif_d   = f_bif;
          accum_d = f_acc;
          if (f_done) begin
            vvalid_d = 1'b1;
            value_d  = cur_accum | lane;
            case (ph)
              P_VERSION: phase_d = P_INCOUNT;
              P_PREVIDX: phase_d = P_INSLEN;
              P_AMOUNT:  phase_d = P_OUTSLEN;
              default: begin
                item_cnt_d  = item_cnt_d + 32'd1;
                list_left_d = list_left_d - LEN_ONE;
                if (list_left_d == '0) begin
                  phase_d = P_OUTCOUNT;
                end else begin
                  pay_left_d = PREVHASH_LEN;
                  phase_d    = P_PREVHASH;
                end
              end
            endcase
          end
        end
        P_INCOUNT, P_INCOUNT2, P_INSLEN, P_OUTCOUNT, P_OUTSLEN, P_WITCOUNT,
        P_WITLEN: begin
          if (ph == P_INCOUNT && cur_vleft == 4'd0 && data_byte_i == 8'd0) begin
            kind_d   = K_MARKER;
            txid_d   = 1'b0;
            segwit_d = 1'b1;
            phase_d  = P_FLAG;
          end else begin
            if (ph == P_WITCOUNT || ph == P_WITLEN) begin
              txid_d = 1'b0;
            end
            bif_d   = v_bif;
            vleft_d = v_vleft;
            accum_d = v_acc;
            if (v_done) begin
              vvalid_d = 1'b1;
              value_d  = v_val;
              if (too_big(v_val)) begin
                err_d = ERR_TOO_BIG;
              end else begin
                case (ph)
                  P_INCOUNT, P_INCOUNT2: begin
                    input_total_d = v_val[LENGTH_BITS-1:0];
                    if (v_val == 64'd0) begin
                      phase_d = P_OUTCOUNT;
                    end else begin
                      list_left_d = v_val[LENGTH_BITS-1:0];
                      item_cnt_d  = 32'd0;
                      pay_left_d  = PREVHASH_LEN;
                      phase_d     = P_PREVHASH;
                    end
                  end
                  P_INSLEN: begin
                    pay_left_d = v_val[LENGTH_BITS-1:0];
                    phase_d    = (v_val == 64'd0) ? P_SEQ : P_INSCRIPT;
                  end
                  P_OUTCOUNT: begin
                    if (v_val == 64'd0) begin
                      if (segwit_d && input_total_d != '0) begin
                        list_left_d = input_total_d;
                        item_cnt_d  = 32'd0;
                        phase_d     = P_WITCOUNT;
                      end else begin
                        phase_d = P_LOCK;
                      end
                    end else begin
                      list_left_d = v_val[LENGTH_BITS-1:0];
                      item_cnt_d  = 32'd0;
                      phase_d     = P_AMOUNT;
                    end
                  end
                  P_OUTSLEN: begin
                    if (v_val == 64'd0) begin
                      item_cnt_d  = item_cnt_d + 32'd1;
                      list_left_d = list_left_d - LEN_ONE;
                      if (list_left_d != '0) begin
                        phase_d = P_AMOUNT;
                      end else if (segwit_d && input_total_d != '0) begin
                        list_left_d = input_total_d;
                        item_cnt_d  = 32'd0;
                        phase_d     = P_WITCOUNT;
                      end else begin
                        phase_d = P_LOCK;
                      end
                    end else begin
                      pay_left_d = v_val[LENGTH_BITS-1:0];
                      phase_d    = P_OUTSCRIPT;
                    end
                  end
                  P_WITCOUNT: begin
                    if (v_val == 64'd0) begin
                      item_cnt_d  = item_cnt_d + 32'd1;
                      list_left_d = list_left_d - LEN_ONE;
                      phase_d     = (list_left_d == '0) ? P_LOCK : P_WITCOUNT;
                    end else begin
                      wit_left_d = v_val[LENGTH_BITS-1:0];
                      phase_d    = P_WITLEN;
                    end
                  end
                  default: begin
                    if (v_val == 64'd0) begin
                      wit_left_d = wit_left_d - LEN_ONE;
                      if (wit_left_d == '0) begin
                        item_cnt_d  = item_cnt_d + 32'd1;
                        list_left_d = list_left_d - LEN_ONE;
                        phase_d     = (list_left_d == '0) ? P_LOCK : P_WITCOUNT;
                      end else begin
                        phase_d = P_WITLEN;
                      end
                    end else begin
                      pay_left_d = v_val[LENGTH_BITS-1:0];
                      phase_d    = P_WITBYTE;
                    end
                  end
                endcase
              end
            end
          end
        end
        P_FLAG: begin
          txid_d   = 1'b0;
          vvalid_d = 1'b1;
          value_d  = {56'd0, data_byte_i};
          if (data_byte_i != SEGWIT_FLAG) begin
            err_d = ERR_BAD_FLAG;
          end else begin
            phase_d = P_INCOUNT2;
          end
        end
        P_PREVHASH, P_INSCRIPT, P_OUTSCRIPT, P_WITBYTE: begin
          if (ph == P_WITBYTE) begin
            txid_d = 1'b0;
          end
          pay_left_d = pay_left_d - LEN_ONE;
          if (pay_left_d == '0) begin
            case (ph)
              P_PREVHASH: phase_d = P_PREVIDX;
              P_INSCRIPT: phase_d = P_SEQ;
              P_OUTSCRIPT: begin
                item_cnt_d  = item_cnt_d + 32'd1;
                list_left_d = list_left_d - LEN_ONE;
                if (list_left_d != '0) begin
                  phase_d = P_AMOUNT;
                end else if (segwit_d && input_total_d != '0) begin
                  list_left_d = input_total_d;
                  item_cnt_d  = 32'd0;
                  phase_d     = P_WITCOUNT;
                end else begin
                  phase_d = P_LOCK;
                end
              end
              default: begin
                wit_left_d = wit_left_d - LEN_ONE;
                if (wit_left_d == '0) begin
                  item_cnt_d  = item_cnt_d + 32'd1;
                  list_left_d = list_left_d - LEN_ONE;
                  phase_d     = (list_left_d == '0) ? P_LOCK : P_WITCOUNT;
                end else begin
                  phase_d = P_WITLEN;
                end
              end
            endcase
          end
        end
        default: begin
          bif_d   = f_bif;
          accum_d = f_acc;
          if (f_done) begin
            vvalid_d = 1'b1;
            value_d  = cur_accum | lane;
            done_d   = 1'b1;
            phase_d  = P_IDLE;
          end
        end
      endcase

      if (txid_d) begin
        strip_cnt_d = strip_cnt_d + 32'd1;
      end
      if (err_d != ERR_NONE) begin
        phase_d = P_SKIP;
      end
    end

    total_len_d = done_d ? total_cnt_d : 32'd0;
    strip_len_d = done_d ? strip_cnt_d : 32'd0;
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= P_IDLE;
      bif_q         <= 4'd0;
      vleft_q       <= 4'd0;
      accum_q       <= 64'd0;
      segwit_q      <= 1'b0;
      input_total_q <= '0;
      list_left_q   <= '0;
      wit_left_q    <= '0;
      pay_left_q    <= '0;
      item_cnt_q    <= 32'd0;
      total_cnt_q   <= 32'd0;
      strip_cnt_q   <= 32'd0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q       <= phase_d;
        bif_q         <= bif_d;
        vleft_q       <= vleft_d;
        accum_q       <= accum_d;
        segwit_q      <= segwit_d;
        input_total_q <= input_total_d;
        list_left_q   <= list_left_d;
        wit_left_q    <= wit_left_d;
        pay_left_q    <= pay_left_d;
        item_cnt_q    <= item_cnt_d;
        total_cnt_q   <= total_cnt_d;
        strip_cnt_q   <= strip_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_d;
      data_q      <= data_byte_i;
      txid_q      <= txid_d;
      vvalid_q    <= vvalid_d;
      value_q     <= value_d;
      index_q     <= index_d;
      done_q      <= done_d;
      total_len_q <= total_len_d;
      strip_len_q <= strip_len_d;
      is_segwit_q <= segwit_d;
      err_q       <= err_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign field_kind_o      = kind_q;
  assign data_out_o        = data_q;
  assign in_txid_o         = txid_q;
  assign value_valid_o     = vvalid_q;
  assign field_value_o     = value_q;
  assign item_index_o      = index_q;
  assign tx_done_o         = done_q;
  assign total_length_o    = total_len_q;
  assign stripped_length_o = strip_len_q;
  assign is_segwit_o       = is_segwit_q;
  assign error_code_o      = err_q;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Transaction stream parser testbench
// Streams serialized transactions into segwit_transaction_stream_parser one
// byte per item: a few hand-made cases first, then random well-formed legacy
// and segwit transactions mixed with bad flags, oversize varints, cut-off
// transactions and stray bytes. A byte-level parse model predicts every
// result, which is checked field by field against what the block returns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swtsp_pkg::*;

  localparam logic [7:0] SEGWIT_MARKER   = 8'h00;
  localparam logic [7:0] VARINT_PREFIX64 = 8'hff;
  localparam int         RANDOM_BYTES    = 1050;
  localparam int         NO_CUT          = 32'h7fff_ffff;

  typedef struct {
    logic [7:0] value;
    logic       first;
    bit         hold;
  } stream_byte_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [7:0]        data;
    logic              txid;
    logic              vvalid;
    logic [63:0]       value;
    logic [31:0]       index;
    logic              done;
    logic [31:0]       total;
    logic [31:0]       stripped;
    logic              segwit;
    logic [ERR_W-1:0]  err;
  } parse_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i = 8'h00;
  logic              start_of_tx_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [KIND_W-1:0] field_kind_o;
  logic [7:0]        data_out_o;
  logic              in_txid_o;
  logic              value_valid_o;
  logic [63:0]       field_value_o;
  logic [31:0]       item_index_o;
  logic              tx_done_o;
  logic [31:0]       total_length_o;
  logic [31:0]       stripped_length_o;
  logic              is_segwit_o;
  logic [ERR_W-1:0]  error_code_o;

  segwit_transaction_stream_parser uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .start_of_tx_i    (start_of_tx_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .field_kind_o     (field_kind_o),
    .data_out_o       (data_out_o),
    .in_txid_o        (in_txid_o),
    .value_valid_o    (value_valid_o),
    .field_value_o    (field_value_o),
    .item_index_o     (item_index_o),
    .tx_done_o        (tx_done_o),
    .total_length_o   (total_length_o),
    .stripped_length_o(stripped_length_o),
    .is_segwit_o      (is_segwit_o),
    .error_code_o     (error_code_o)
  );

  always #5ns clk_i = ~clk_i;

  stream_byte_t  pending_bytes[$];
  parse_result_t expected_results[$];
  int            error_count = 0;

  // Parse model state.
  logic [PHASE_W-1:0] parse_phase = P_IDLE;
  logic [3:0]         field_pos = '0;
  logic [3:0]         varint_left = '0;
  logic [63:0]        accum = '0;
  logic               segwit_flag = 1'b0;
  logic [63:0]        inputs_declared = '0;
  logic [63:0]        list_left = '0;
  logic [63:0]        wit_left = '0;
  logic [63:0]        payload_left = '0;
  logic [31:0]        cur_index = '0;
  logic [31:0]        len_total = '0;
  logic [31:0]        len_stripped = '0;

  // Stimulus generation state.
  int byte_budget = NO_CUT;
  int oversize_slot = 0;
  int tx_bytes = 0;

  task automatic report_error(input string msg);
    error_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string fname, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("%s is %0h, expected %0h", fname, got, want));
  endtask

  function automatic logic exceeds_length(input logic [63:0] v);
    return (v >> LENGTH_BITS) != 64'd0;
  endfunction

  function automatic logic take_fixed(input logic [7:0] b, input logic [3:0] n,
                                      output logic [63:0] v);
    accum = accum | ({56'd0, b} << {field_pos[2:0], 3'b000});
    field_pos = field_pos + 4'd1;
    v = accum;
    if (field_pos >= n) begin
      accum = '0;
      field_pos = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic take_varint(input logic [7:0] b, output logic [63:0] v);
    v = {56'd0, b};
    if (varint_left == 4'd0) begin
      if (b < VARINT_PREFIX16) return 1'b1;
      varint_left = (b == VARINT_PREFIX16) ? VARINT_BYTES16 :
                    (b == VARINT_PREFIX32) ? VARINT_BYTES32 : VARINT_BYTES64;
      accum = '0;
      field_pos = '0;
      return 1'b0;
    end
    accum = accum | ({56'd0, b} << {field_pos[2:0], 3'b000});
    field_pos = field_pos + 4'd1;
    varint_left = varint_left - 4'd1;
    v = accum;
    if (varint_left == 4'd0) begin
      accum = '0;
      field_pos = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void finish_outputs();
    if (segwit_flag && inputs_declared != 64'd0) begin
      list_left = inputs_declared;
      cur_index = '0;
      parse_phase = P_WITCOUNT;
    end else begin
      parse_phase = P_LOCK;
    end
  endfunction

  function automatic void finish_output();
    cur_index = cur_index + 32'd1;
    list_left = list_left - 64'd1;
    if (list_left == 64'd0) finish_outputs();
    else parse_phase = P_AMOUNT;
  endfunction

  function automatic void finish_witness_input();
    cur_index = cur_index + 32'd1;
    list_left = list_left - 64'd1;
    parse_phase = (list_left == 64'd0) ? P_LOCK : P_WITCOUNT;
  endfunction

  function automatic void finish_witness_item();
    wit_left = wit_left - 64'd1;
    if (wit_left == 64'd0) finish_witness_input();
    else parse_phase = P_WITLEN;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic s);
    parse_result_t r;
    logic [PHASE_W-1:0] ph;
    logic [63:0] v;
    r = '{default: '0};
    v = '0;
    r.data = b;
    r.txid = 1'b1;
    if (s) begin
      field_pos = '0;
      varint_left = '0;
      accum = '0;
      segwit_flag = 1'b0;
      inputs_declared = '0;
      list_left = '0;
      wit_left = '0;
      payload_left = '0;
      cur_index = '0;
      len_total = '0;
      len_stripped = '0;
      parse_phase = P_VERSION;
    end
    ph = parse_phase;
    case (ph)
      P_VERSION:              r.kind = K_VERSION;
      P_INCOUNT, P_INCOUNT2:  r.kind = K_INCOUNT;
      P_FLAG:                 r.kind = K_FLAG;
      P_PREVHASH:             r.kind = K_PREVHASH;
      P_PREVIDX:              r.kind = K_PREVIDX;
      P_INSLEN:               r.kind = K_INSCRIPTLEN;
      P_INSCRIPT:             r.kind = K_INSCRIPT;
      P_SEQ:                  r.kind = K_SEQ;
      P_OUTCOUNT:             r.kind = K_OUTCOUNT;
      P_AMOUNT:               r.kind = K_AMOUNT;
      P_OUTSLEN:              r.kind = K_OUTSCRIPTLEN;
      P_OUTSCRIPT:            r.kind = K_OUTSCRIPT;
      P_WITCOUNT:             r.kind = K_WITCOUNT;
      P_WITLEN:               r.kind = K_WITLEN;
      P_WITBYTE:              r.kind = K_WITBYTE;
      P_LOCK:                 r.kind = K_LOCKTIME;
      default:                r.kind = K_SKIPPED;
    endcase

    if (ph == P_IDLE || ph >= P_SKIP) begin
      r.txid = 1'b0;
    end else begin
      len_total = len_total + 32'd1;
      if ((ph >= P_PREVHASH && ph <= P_SEQ) || (ph >= P_AMOUNT && ph <= P_WITBYTE))
        r.index = cur_index;
      case (ph)
        P_VERSION: begin
          if (take_fixed(b, FIXED_BYTES32, v)) begin
            r.vvalid = 1'b1;
            parse_phase = P_INCOUNT;
          end
        end
        P_INCOUNT, P_INCOUNT2: begin
          if (ph == P_INCOUNT && varint_left == 4'd0 && b == SEGWIT_MARKER) begin
            r.kind = K_MARKER;
            r.txid = 1'b0;
            segwit_flag = 1'b1;
            parse_phase = P_FLAG;
          end else if (take_varint(b, v)) begin
            r.vvalid = 1'b1;
            if (exceeds_length(v)) begin
              r.err = ERR_TOO_BIG;
            end else begin
              inputs_declared = v;
              if (v == 64'd0) begin
                parse_phase = P_OUTCOUNT;
              end else begin
                list_left = v;
                cur_index = '0;
                payload_left = 64'(PREVHASH_BYTES);
                parse_phase = P_PREVHASH;
              end
            end
          end
        end
        P_FLAG: begin
          r.txid = 1'b0;
          r.vvalid = 1'b1;
          v = {56'd0, b};
          if (b != SEGWIT_FLAG) r.err = ERR_BAD_FLAG;
          else parse_phase = P_INCOUNT2;
        end
        P_PREVHASH: begin
          payload_left = payload_left - 64'd1;
          if (payload_left == 64'd0) parse_phase = P_PREVIDX;
        end
        P_PREVIDX: begin
          if (take_fixed(b, FIXED_BYTES32, v)) begin
            r.vvalid = 1'b1;
            parse_phase = P_INSLEN;
          end
        end
        P_INSLEN: begin
          if (take_varint(b, v)) begin
            r.vvalid = 1'b1;
            if (exceeds_length(v)) begin
              r.err = ERR_TOO_BIG;
            end else begin
              payload_left = v;
              parse_phase = (v == 64'd0) ? P_SEQ : P_INSCRIPT;
            end
          end
        end
        P_INSCRIPT: begin
          payload_left = payload_left - 64'd1;
          if (payload_left == 64'd0) parse_phase = P_SEQ;
        end
        P_SEQ: begin
          if (take_fixed(b, FIXED_BYTES32, v)) begin
            r.vvalid = 1'b1;
            cur_index = cur_index + 32'd1;
            list_left = list_left - 64'd1;
            if (list_left == 64'd0) begin
              parse_phase = P_OUTCOUNT;
            end else begin
              payload_left = 64'(PREVHASH_BYTES);
              parse_phase = P_PREVHASH;
            end
          end
        end
        P_OUTCOUNT: begin
          if (take_varint(b, v)) begin
            r.vvalid = 1'b1;
            if (exceeds_length(v)) begin
              r.err = ERR_TOO_BIG;
            end else if (v == 64'd0) begin
              finish_outputs();
            end else begin
              list_left = v;
              cur_index = '0;
              parse_phase = P_AMOUNT;
            end
          end
        end
        P_AMOUNT: begin
          if (take_fixed(b, FIXED_BYTES64, v)) begin
            r.vvalid = 1'b1;
            parse_phase = P_OUTSLEN;
          end
        end
        P_OUTSLEN: begin
          if (take_varint(b, v)) begin
            r.vvalid = 1'b1;
            if (exceeds_length(v)) begin
              r.err = ERR_TOO_BIG;
            end else if (v == 64'd0) begin
              finish_output();
            end else begin
              payload_left = v;
              parse_phase = P_OUTSCRIPT;
            end
          end
        end
        P_OUTSCRIPT: begin
          payload_left = payload_left - 64'd1;
          if (payload_left == 64'd0) finish_output();
        end
        P_WITCOUNT: begin
          r.txid = 1'b0;
          if (take_varint(b, v)) begin
            r.vvalid = 1'b1;
            if (exceeds_length(v)) begin
              r.err = ERR_TOO_BIG;
            end else if (v == 64'd0) begin
              finish_witness_input();
            end else begin
              wit_left = v;
              parse_phase = P_WITLEN;
            end
          end
        end
        P_WITLEN: begin
          r.txid = 1'b0;
          if (take_varint(b, v)) begin
            r.vvalid = 1'b1;
            if (exceeds_length(v)) begin
              r.err = ERR_TOO_BIG;
            end else if (v == 64'd0) begin
              finish_witness_item();
            end else begin
              payload_left = v;
              parse_phase = P_WITBYTE;
            end
          end
        end
        P_WITBYTE: begin
          r.txid = 1'b0;
          payload_left = payload_left - 64'd1;
          if (payload_left == 64'd0) finish_witness_item();
        end
        default: begin
          if (take_fixed(b, FIXED_BYTES32, v)) begin
            r.vvalid = 1'b1;
            r.done = 1'b1;
            parse_phase = P_IDLE;
          end
        end
      endcase
      if (r.txid) len_stripped = len_stripped + 32'd1;
      if (r.err != ERR_NONE) parse_phase = P_SKIP;
    end

    r.value = r.vvalid ? v : 64'd0;
    r.total = r.done ? len_total : 32'd0;
    r.stripped = r.done ? len_stripped : 32'd0;
    r.segwit = segwit_flag;
    expected_results.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic s);
    if (byte_budget == 0) return;
    byte_budget--;
    tx_bytes++;
    pending_bytes.push_back('{value: b, first: s, hold: 1'b0});
  endtask

  task automatic add_noise(input int n);
    repeat (n) pending_bytes.push_back('{value: 8'($urandom), first: 1'b0, hold: 1'b0});
  endtask

  task automatic push_fixed(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) push_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic push_varint(input logic [63:0] v);
    int need;
    int form;
    need = (v < 64'(VARINT_PREFIX16)) ? 0 : (v <= 64'hffff) ? 1 :
           (v <= 64'hffff_ffff) ? 2 : 3;
    form = ($urandom_range(4, 0) == 0) ? $urandom_range(3, need) : need;
    case (form)
      0: push_byte(v[7:0], 1'b0);
      1: begin
        push_byte(VARINT_PREFIX16, 1'b0);
        push_fixed(v, 2);
      end
      2: begin
        push_byte(VARINT_PREFIX32, 1'b0);
        push_fixed(v, 4);
      end
      default: begin
        push_byte(VARINT_PREFIX64, 1'b0);
        push_fixed(v, 8);
      end
    endcase
  endtask

  // A count or length; the chosen one is replaced by a value too large for
  // the block, and the rest of the transaction is then dropped.
  task automatic push_count(input logic [63:0] v);
    logic [63:0] huge;
    if (oversize_slot == 1) begin
      case ($urandom_range(2, 0))
        0:       huge = 64'h1_0000_0000;
        1:       huge = '1;
        default: huge = {32'($urandom_range(32'hffff_ffff, 1)), 32'($urandom)};
      endcase
      push_byte(VARINT_PREFIX64, 1'b0);
      push_fixed(huge, 8);
      byte_budget = 0;
    end else begin
      push_varint(v);
    end
    if (oversize_slot != 0) oversize_slot--;
  endtask

  function automatic int pick_len();
    return ($urandom_range(39, 0) == 0) ? $urandom_range(300, 253) : $urandom_range(6, 0);
  endfunction

  task automatic gen_tx(input bit segwit, input logic [7:0] flag, input int n_in,
                        input int n_out);
    logic [31:0] version;
    int len;
    int wits;
    int form;
    version = $urandom;
    push_byte(version[7:0], 1'b1);
    push_fixed({32'd0, version} >> 8, 3);
    if (segwit) begin
      push_byte(SEGWIT_MARKER, 1'b0);
      push_byte(flag, 1'b0);
      if (flag != SEGWIT_FLAG) byte_budget = 0;
    end
    if (!segwit && n_in == 0) begin
      // A single zero byte here would be the marker, so use a wide zero.
      form = $urandom_range(3, 1);
      push_byte(form == 1 ? VARINT_PREFIX16 : form == 2 ? VARINT_PREFIX32 : VARINT_PREFIX64,
                1'b0);
      push_fixed(64'd0, form == 1 ? 2 : form == 2 ? 4 : 8);
    end else begin
      push_count(64'(n_in));
    end
    for (int i = 0; i < n_in; i++) begin
      repeat (PREVHASH_BYTES) push_byte(8'($urandom), 1'b0);
      push_fixed(64'($urandom), 4);
      len = pick_len();
      push_count(64'(len));
      repeat (len) push_byte(8'($urandom), 1'b0);
      push_fixed(64'($urandom), 4);
    end
    push_count(64'(n_out));
    for (int i = 0; i < n_out; i++) begin
      push_fixed({$urandom, $urandom}, 8);
      len = pick_len();
      push_count(64'(len));
      repeat (len) push_byte(8'($urandom), 1'b0);
    end
    if (segwit && n_in != 0) begin
      for (int i = 0; i < n_in; i++) begin
        wits = $urandom_range(3, 0);
        push_count(64'(wits));
        repeat (wits) begin
          len = ($urandom_range(9, 0) == 0) ? $urandom_range(270, 253) : $urandom_range(5, 0);
          push_count(64'(len));
          repeat (len) push_byte(8'($urandom), 1'b0);
        end
      end
    end
    push_fixed(($urandom_range(3, 0) == 0) ? 64'hffff_ffff : 64'($urandom), 4);
    byte_budget = NO_CUT;
    oversize_slot = 0;
  endtask

  // Sender: bursts of random length separated by random gaps.
  logic         byte_taken = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;
  stream_byte_t next_byte;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() == 0 ||
                   (pending_bytes[0].hold && expected_results.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        next_byte = pending_bytes.pop_front();
        in_valid_i <= 1'b1;
        data_byte_i <= next_byte.value;
        start_of_tx_i <= next_byte.first;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(40, 1);
          gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall behaviour changes between a few modes.
  int   stall_mode = 0;
  int   stall_span = 0;
  int   stall_run = 0;
  logic stall_level = 1'b0;

  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(3, 0);
      stall_span = $urandom_range(120, 20);
    end
    stall_span = stall_span - 1;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'($urandom_range(1, 0));
      2: begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(12, 1);
          stall_level = ~stall_level;
        end
        stall_run = stall_run - 1;
        out_stall_i <= stall_level;
      end
      default: out_stall_i <= ($urandom_range(3, 0) == 0);
    endcase
  end

  parse_result_t want;

  always @(posedge clk_i) begin
    byte_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result for byte %0h", data_out_o));
        end else begin
          want = expected_results.pop_front();
          compare_field("field_kind", 64'(field_kind_o), 64'(want.kind));
          compare_field("data_out", 64'(data_out_o), 64'(want.data));
          compare_field("in_txid", 64'(in_txid_o), 64'(want.txid));
          compare_field("value_valid", 64'(value_valid_o), 64'(want.vvalid));
          compare_field("field_value", field_value_o, want.value);
          compare_field("item_index", 64'(item_index_o), 64'(want.index));
          compare_field("tx_done", 64'(tx_done_o), 64'(want.done));
          compare_field("total_length", 64'(total_length_o), 64'(want.total));
          compare_field("stripped_length", 64'(stripped_length_o), 64'(want.stripped));
          compare_field("is_segwit", 64'(is_segwit_o), 64'(want.segwit));
          compare_field("error_code", 64'(error_code_o), 64'(want.err));
        end
      end
      if (in_valid_i && !in_stall_o) parse_byte(data_byte_i, start_of_tx_i);
    end
  end

  initial begin
    int    pick;
    int    directed_count;
    bit    segwit;
    int    n_in;
    int    n_out;
    logic [7:0] flag;

    // Stray bytes while waiting for a start.
    pending_bytes.push_back('{value: 8'hff, first: 1'b0, hold: 1'b0});
    pending_bytes.push_back('{value: 8'h00, first: 1'b0, hold: 1'b0});
    // Legacy transaction with a wide zero input count and no outputs.
    push_byte(8'hff, 1'b1);
    push_fixed(64'hff_ffff, 3);
    push_byte(VARINT_PREFIX16, 1'b0);
    push_fixed(64'd0, 2);
    push_byte(8'h00, 1'b0);
    push_fixed(64'd0, 4);
    // Marker followed by a bad flag, then a byte that is skipped.
    push_byte(8'h01, 1'b1);
    push_fixed(64'd0, 3);
    push_byte(SEGWIT_MARKER, 1'b0);
    push_byte(8'h00, 1'b0);
    pending_bytes.push_back('{value: 8'h5a, first: 1'b0, hold: 1'b0});
    // A transaction abandoned after two version bytes.
    push_byte(8'h02, 1'b1);
    push_byte(8'h00, 1'b0);
    directed_count = pending_bytes.size();

    tx_bytes = 0;
    while (tx_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(99, 0);
      segwit = 1'($urandom_range(1, 0));
      n_in = $urandom_range(2, 0);
      n_out = $urandom_range(3, 0);
      if (pick < 62) begin
        gen_tx(segwit, SEGWIT_FLAG, n_in, n_out);
      end else if (pick < 74) begin
        oversize_slot = $urandom_range(6, 1);
        gen_tx(segwit, SEGWIT_FLAG, n_in, n_out);
        add_noise($urandom_range(3, 0));
      end else if (pick < 84) begin
        flag = ($urandom_range(3, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 2));
        gen_tx(1'b1, flag, n_in, n_out);
        add_noise($urandom_range(3, 0));
      end else if (pick < 94) begin
        byte_budget = $urandom_range(80, 1);
        gen_tx(segwit, SEGWIT_FLAG, n_in, n_out);
      end else begin
        add_noise($urandom_range(4, 1));
      end
    end
    pending_bytes[directed_count].hold = 1'b1;
    pending_bytes[directed_count + (pending_bytes.size() - directed_count) / 2].hold = 1'b1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));

    if (error_count == 0) begin
      $display("[segwit_transaction_stream_parser] OK");
    end else begin
      $display("[segwit_transaction_stream_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("[segwit_transaction_stream_parser] ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/swtsp_pkg.sv
rtl/segwit_transaction_stream_parser.sv
test/testbench.sv
